// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/i2cbb_pkg.sv -----
// Shared types, codes and reset constants of the I2C bit-bang master.
package i2cbb_pkg;

    // Command codes on the func field.
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_RSTART = 3'd2;
    localparam logic [2:0] FUNC_WRITE  = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;
    localparam logic [2:0] FUNC_STOP   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PHASE = 2'd0;
    localparam logic [1:0] CFG_WAIT  = 2'd1;

    // Reset values and defaults.
    localparam logic [15:0] PHASE_TICKS_RST = 16'd40;
    localparam logic [15:0] WAIT_TICKS_RST  = 16'd80;
    localparam int          TIMER_BITS_DEF  = 16;

    // Byte handling.
    localparam logic [7:0] MSB_MASK  = 8'h80;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // One result of the sequencer.
    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
        logic       rejected;
    } t_result;

endpackage

// ----- sv/i2cbb_core.sv -----
// Pin sequencer of the I2C master: step state, phase timer, shifter and pins.
module i2cbb_core
    import i2cbb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_nack,
    input  logic        i_sda_level,
    input  logic [15:0] i_phase_ticks,
    input  logic [15:0] i_wait_ticks,
    output t_result     o_res
);

    typedef enum logic [4:0] {
        S_IDLE, ST_SCLH, ST_SDAL, ST_WAIT, ST_SCLL, RS_SDAH, RS_WAIT,
        W_SCLL, W_BIT, W_BH, W_BL, W_REL, W_AH, W_AL, W_DRV,
        R_SCLL, R_BH, R_BL, R_ACK, R_AH, R_AL, R_DRV,
        P_SCLH, P_SDAH, P_WAIT
    } t_step;

    typedef struct packed {
        logic scl;
        logic sda;
        logic en;
    } t_pins;

    t_step                 r_step, n_step;
    logic [TIMER_BITS-1:0] r_cnt, n_cnt;
    logic [7:0]            r_shift, n_shift;
    logic [3:0]            r_bits, n_bits;
    logic                  r_ack, n_ack;
    logic                  r_nack, n_nack;
    logic [7:0]            r_rx, n_rx;
    t_pins                 r_pins, n_pins;

    logic [TIMER_BITS+15:0] v_p_ext, v_w_ext;
    logic [TIMER_BITS-1:0]  v_p, v_w, v_dec;
    logic                   v_enter, v_done, v_rej;
    t_step                  v_next, v_next2;
    t_pins                  v_pins1;

    // Pin levels set on entry to a step.
    function automatic t_pins enter_pins(t_step s, t_pins cur, logic msb, logic ack);
        t_pins v;
        v = cur;
        case (s) inside
            ST_SCLH, W_BH, W_AH, R_BH, R_AH, P_SCLH: v.scl = 1'b1;
            ST_SCLL, W_BL, W_AL, R_BL, R_AL, W_SCLL: v.scl = 1'b0;
            ST_SDAL, W_DRV, R_DRV: begin
                v.sda = 1'b0;
                v.en  = 1'b1;
            end
            RS_SDAH, P_SDAH: begin
                v.sda = 1'b1;
                v.en  = 1'b1;
            end
            W_BIT: begin
                v.sda = msb;
                v.en  = 1'b1;
            end
            W_REL: v.en = 1'b0;
            R_SCLL: begin
                v.scl = 1'b0;
                v.en  = 1'b0;
            end
            R_ACK: begin
                v.sda = ack;
                v.en  = 1'b1;
            end
            default: v = cur;
        endcase
        return v;
    endfunction

    // Steps timed by the settle wait rather than the pin phase.
    function automatic logic is_wait(t_step s);
        return (s == ST_WAIT) || (s == RS_WAIT) || (s == P_WAIT) || (s == W_REL);
    endfunction

    // Step that follows a settle wait.
    function automatic t_step wait_succ(t_step s);
        t_step v;
        case (s)
            ST_WAIT: v = ST_SCLL;
            RS_WAIT: v = ST_SCLH;
            W_REL:   v = W_AH;
            default: v = S_IDLE;
        endcase
        return v;
    endfunction

    // Step lengths cut to the timer width; a pin phase lasts at least one tick.
    always_comb begin
        v_p_ext = {{TIMER_BITS{1'b0}}, i_phase_ticks};
        v_w_ext = {{TIMER_BITS{1'b0}}, i_wait_ticks};
        v_p     = v_p_ext[TIMER_BITS-1:0];
        v_w     = v_w_ext[TIMER_BITS-1:0];
        if (v_p == '0) begin
            v_p = TIMER_BITS'(1);
        end
    end

    // Next state for one item: count down, end a step, load a command, or reject one while busy.
    always_comb begin
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_ack   = r_ack;
        n_nack  = r_nack;
        n_rx    = r_rx;
        n_pins  = r_pins;
        v_enter = 1'b0;
        v_done  = 1'b0;
        v_rej   = 1'b0;
        v_next  = S_IDLE;
        v_next2 = S_IDLE;
        v_pins1 = r_pins;
        v_dec   = r_cnt - TIMER_BITS'(1);

        if (i_go) begin
            if (i_func == FUNC_TICK) begin
                if (r_step != S_IDLE) begin
                    if (v_dec != '0) begin
                        n_cnt = v_dec;
                    end else begin
                        v_enter = 1'b1;
                        // End of the current step and its side effects.
                        unique case (r_step)
                            ST_SCLH: v_next = ST_SDAL;
                            ST_SDAL: v_next = ST_WAIT;
                            ST_WAIT: v_next = ST_SCLL;
                            ST_SCLL: v_next = W_SCLL;
                            RS_SDAH: v_next = RS_WAIT;
                            RS_WAIT: v_next = ST_SCLH;
                            W_SCLL:  v_next = W_BIT;
                            W_BIT:   v_next = W_BH;
                            W_BH:    v_next = W_BL;
                            W_BL: begin
                                n_shift = {r_shift[6:0], 1'b0};
                                n_bits  = r_bits + 4'd1;
                                v_next  = (n_bits >= BYTE_BITS) ? W_REL : W_BIT;
                            end
                            W_REL:   v_next = W_AH;
                            W_AH: begin
                                n_nack = i_sda_level;
                                v_next = W_AL;
                            end
                            W_AL:    v_next = W_DRV;
                            R_SCLL:  v_next = R_BH;
                            R_BH: begin
                                n_shift = {r_shift[6:0], i_sda_level};
                                v_next  = R_BL;
                            end
                            R_BL: begin
                                n_bits = r_bits + 4'd1;
                                if (n_bits >= BYTE_BITS) begin
                                    n_rx   = r_shift;
                                    v_next = R_ACK;
                                end else begin
                                    v_next = R_BH;
                                end
                            end
                            R_ACK:   v_next = R_AH;
                            R_AH:    v_next = R_AL;
                            R_AL:    v_next = R_DRV;
                            P_SCLH:  v_next = P_SDAH;
                            P_SDAH:  v_next = P_WAIT;
                            default: v_next = S_IDLE;
                        endcase
                    end
                end
            end else if (i_func <= FUNC_STOP) begin
                if (r_step != S_IDLE) begin
                    v_rej = 1'b1;
                end else begin
                    v_enter = 1'b1;
                    // First step of the new command.
                    unique case (i_func)
                        FUNC_START: begin
                            n_shift = i_tx_byte;
                            v_next  = ST_SCLH;
                        end
                        FUNC_RSTART: begin
                            n_shift = i_tx_byte;
                            v_next  = RS_SDAH;
                        end
                        FUNC_WRITE: begin
                            n_shift = i_tx_byte;
                            v_next  = W_SCLL;
                        end
                        FUNC_READ: begin
                            n_ack  = i_send_nack;
                            v_next = R_SCLL;
                        end
                        default: v_next = P_SCLH;
                    endcase
                end
            end
        end

        // Enter the next step, passing one settle wait of zero length.
        if (v_enter) begin
            if (v_next == S_IDLE) begin
                n_step = S_IDLE;
                n_cnt  = '0;
                v_done = 1'b1;
            end else begin
                v_pins1 = enter_pins(v_next, r_pins, (n_shift & MSB_MASK) != 8'd0, n_ack);
                if (v_next == W_SCLL) begin
                    n_bits = '0;
                end
                if (v_next == R_SCLL) begin
                    n_bits  = '0;
                    n_shift = '0;
                end
                if (is_wait(v_next) && (v_w == '0)) begin
                    v_next2 = wait_succ(v_next);
                    if (v_next2 == S_IDLE) begin
                        n_step = S_IDLE;
                        n_cnt  = '0;
                        n_pins = v_pins1;
                        v_done = 1'b1;
                    end else begin
                        n_pins = enter_pins(v_next2, v_pins1,
                                            (n_shift & MSB_MASK) != 8'd0, n_ack);
                        n_step = v_next2;
                        n_cnt  = v_p;
                    end
                end else begin
                    n_pins = v_pins1;
                    n_step = v_next;
                    n_cnt  = is_wait(v_next) ? v_w : v_p;
                end
            end
        end
    end

    // Result of this item, taken by the output register.
    always_comb begin
        o_res.scl_level  = n_pins.scl;
        o_res.sda_drive  = n_pins.sda;
        o_res.sda_enable = n_pins.en;
        o_res.busy_res   = (n_step != S_IDLE);
        o_res.done_res   = v_done;
        o_res.rx_byte    = n_rx;
        o_res.nack_seen  = n_nack;
        o_res.rejected   = v_rej;
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_bits  <= '0;
            r_ack   <= 1'b0;
            r_nack  <= 1'b0;
            r_rx    <= '0;
            r_pins  <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
        end else begin
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_ack   <= n_ack;
            r_nack  <= n_nack;
            r_rx    <= n_rx;
            r_pins  <= n_pins;
        end
    end

endmodule

// ----- sv/i2c_bit_bang_master.sv -----
// Top level of the I2C bit-bang master: config registers, input and output stages.
//
// Requests arrive on the input channel (i_in_valid / o_in_ready) as a func
// code with its payload: a tick, or a start, repeated start, write, read or
// stop command. Every request gives exactly one result on the output channel
// (o_out_valid / i_out_ready): the pin levels after the request, busy and done
// flags, the last received byte, the last ACK bit and a rejected flag.
// Commands are taken only while no sequence runs; a command that arrives while
// busy is flagged as rejected and changes nothing.
// An accepted request sits in the input register, and the sequencer's result
// is taken by the output register once that register is free.
// The sequencer handles each request combinationally.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register, the input
// register still takes one more request, and then o_in_ready drops.
// The configuration channel writes phase_ticks (index 0) or wait_ticks
// (index 1) and is always ready; other indexes are ignored. Reset restores
// 40 and 80 ticks, leaves the sequencer idle with SCL and SDA driven high,
// and empties both stages.
module i2c_bit_bang_master
    import i2cbb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_nack,
    input  logic        i_sda_level,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_level,
    output logic        o_sda_drive,
    output logic        o_sda_enable,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rx_byte,
    output logic        o_nack_seen,
    output logic        o_rejected,
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_phase_ticks;
    logic [15:0] r_wait_ticks;
    logic        r_in_valid;
    logic [2:0]  r_in_func;
    logic [7:0]  r_in_tx_byte;
    logic        r_in_send_nack;
    logic        r_in_sda_level;
    logic        r_out_valid;
    t_result     r_res;
    t_result     w_res;
    logic        w_advance;
    logic        w_go;

    // Handshake: the input stage moves on when the output register is free.
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_go        = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_wait_ticks  <= WAIT_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PHASE: r_phase_ticks <= i_cfg_data;
                CFG_WAIT:  r_wait_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_func      <= i_func;
            r_in_tx_byte   <= i_tx_byte;
            r_in_send_nack <= i_send_nack;
            r_in_sda_level <= i_sda_level;
        end
    end

    // Sequencer.
    i2cbb_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (w_go),
        .i_func       (r_in_func),
        .i_tx_byte    (r_in_tx_byte),
        .i_send_nack  (r_in_send_nack),
        .i_sda_level  (r_in_sda_level),
        .i_phase_ticks(r_phase_ticks),
        .i_wait_ticks (r_wait_ticks),
        .o_res        (w_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_level  = r_res.scl_level;
    assign o_sda_drive  = r_res.sda_drive;
    assign o_sda_enable = r_res.sda_enable;
    assign o_busy_res   = r_res.busy_res;
    assign o_done_res   = r_res.done_res;
    assign o_rx_byte    = r_res.rx_byte;
    assign o_nack_seen  = r_res.nack_seen;
    assign o_rejected   = r_res.rejected;

endmodule

// ----- sv/i2cbb_chk.sv -----
// Port-level checker for the I2C bit-bang master and its bind statement.
`include "assert_macros.svh"

module i2cbb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_level,
    input logic       o_sda_drive,
    input logic       o_sda_enable,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte,
    input logic       o_nack_seen,
    input logic       o_rejected
);

    logic        w_stall;
    logic [14:0] w_res_bits;

    // Stall condition and all result fields, gathered for the hold check.
    assign w_stall    = o_out_valid && !i_out_ready;
    assign w_res_bits = {o_scl_level, o_sda_drive, o_sda_enable, o_busy_res, o_done_res,
                         o_rx_byte, o_nack_seen, o_rejected};

    // A stalled result stays valid and unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_out_valid && $stable(w_res_bits))

    // A command is only rejected while a sequence is still running.
    `ASSERT_SAME(a_rej_busy, i_clk, i_rst_n, o_out_valid && o_rejected, o_busy_res && !o_done_res)

    // A finished sequence leaves the master idle.
    `ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)

    // When idle the master always drives SDA.
    `ASSERT_SAME(a_idle_drive, i_clk, i_rst_n, o_out_valid && !o_busy_res, o_sda_enable)

endmodule

bind i2c_bit_bang_master i2cbb_chk u_i2cbb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_scl_level (o_scl_level),
    .o_sda_drive (o_sda_drive),
    .o_sda_enable(o_sda_enable),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_rx_byte   (o_rx_byte),
    .o_nack_seen (o_nack_seen),
    .o_rejected  (o_rejected)
);
